// ----- design/rcfr_pkg.sv -----
package rcfr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_CELLS  = 1024;
    localparam int DEF_FLOW_WIDTH = 32;

    // Field widths of the stream words.
    localparam int IDX_W    = 10;
    localparam int RUNOFF_W = 32;
    localparam int COEF_W   = 18;
    localparam int DOWN_W   = 11;
    localparam int OUT_W    = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 11;
    localparam int COEFS_W  = 3 * COEF_W;

    // Input word layout, lowest bit first.
    localparam int S_DATA_W   = 112;
    localparam int IDX_LSB    = 0;
    localparam int RUNOFF_LSB = IDX_LSB + IDX_W;
    localparam int COEFA_LSB  = RUNOFF_LSB + RUNOFF_W;
    localparam int COEFB_LSB  = COEFA_LSB + COEF_W;
    localparam int COEFC_LSB  = COEFB_LSB + COEF_W;
    localparam int DOWN_LSB   = COEFC_LSB + COEF_W;

    localparam logic [CNT_W-1:0] CELL_COUNT_RESET = 11'd1024;

    // Item kinds carried in s_tuser.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // Result status codes carried in m_tuser.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic take;       // input word accepted this cycle
        logic acc_step;   // runoff add, downstream accumulator read
        logic mul_a;      // product of coef_a and updated inflow
        logic mul_b;      // product of coef_b and previous inflow
        logic mul_c;      // product of coef_c and previous outflow
        logic sum_step;   // last partial sum
        logic rnd;        // round, saturate, store outflow
        logic down;       // add outflow into the downstream cell
        logic in_result;  // result stage, clears the own accumulator
        logic out_load;   // result moves into the output register
    } rcfr_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic route_ok;   // offered word is a route item with a valid index
        logic out_free;   // output register can take a result this cycle
    } rcfr_stat_t;

endpackage

// ----- design/river_cell_flow_routing_core.sv -----
// Muskingum-Cunge flow routing over a river network, one cell per input word.
//
// Input words arrive on the s_ stream. A load word (s_tuser low) stores one
// cell's three Q2.16 coefficients and its one-based downstream link, and it
// clears that cell's flows. A route word (s_tuser high) adds runoff to the
// cell's inflow, forms the weighted outflow, passes it to the downstream
// cell and shifts the cell's flow history. Every word yields one result word
// on the m_ stream: the outflow in Q24.8 and a status code (ok, index out of
// range, saturated). The cfg_ channel sets the number of cells in use; write
// it only while no word is in flight.
//
// A load or rejected word goes straight to the result stage and output
// register; a route word first steps through the accumulator, multiply, sum,
// round and downstream states, set by the single shared multiplier that
// forms the three products one after another and by the read-modify-write
// of the downstream accumulator. One word is worked on at a time. The output
// register lets a new word be accepted while the previous result waits for
// m_tready; a word that is done stalls only while that register is full.
// Reset clears the controller and the output valid and sets the cell count
// to 1024. Cell memories are not cleared: load every cell before routing it.
module river_cell_flow_routing_core
    import rcfr_pkg::*;
#(
    parameter int MAX_CELLS  = DEF_MAX_CELLS,
    parameter int FLOW_WIDTH = DEF_FLOW_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // [9:0] cell_index, [41:10] runoff, [59:42] coef_a, [77:60] coef_b,
    // [95:78] coef_c, [106:96] downstream, [111:107] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [0] func
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // [31:0] outflow
    output logic [OUT_W-1:0]    m_tdata,
    // [1:0] status
    output logic [STAT_W-1:0]   m_tuser,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data
);

    rcfr_cmd_t  cmd;
    rcfr_stat_t st;

    // The cell count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    rcfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rcfr_datapath #(
        .MAX_CELLS  (MAX_CELLS),
        .FLOW_WIDTH (FLOW_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

    // A result never overwrites one that the receiver has not yet taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending output word");

    // The output valid only rises after the controller hands over a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("output valid rose without a result");

    // A route word holds off the next input word while it is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && st.route_ok) |=> !s_tready)
        else $error("input accepted during a route computation");

    // Exactly one datapath step is commanded in each working cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $onehot({cmd.acc_step, cmd.mul_a, cmd.mul_b, cmd.mul_c,
                               cmd.sum_step, cmd.rnd, cmd.down, cmd.in_result}))
        else $error("datapath commands overlap");

endmodule

// ----- design/rcfr_ram.sv -----
module rcfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/rcfr_ctrl.sv -----
module rcfr_ctrl
    import rcfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  rcfr_stat_t st,
    output rcfr_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ACC    = 9'b000000010,
        S_MUL_A  = 9'b000000100,
        S_MUL_B  = 9'b000001000,
        S_MUL_C  = 9'b000010000,
        S_SUM    = 9'b000100000,
        S_RND    = 9'b001000000,
        S_DOWN   = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = st.route_ok ? S_ACC : S_RESULT;
                end
            end
            S_ACC:   state_next = S_MUL_A;
            S_MUL_A: state_next = S_MUL_B;
            S_MUL_B: state_next = S_MUL_C;
            S_MUL_C: state_next = S_SUM;
            S_SUM:   state_next = S_RND;
            S_RND:   state_next = S_DOWN;
            S_DOWN:  state_next = S_RESULT;
            S_RESULT: begin
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready      = (state_reg == S_IDLE);
    assign cmd.take      = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.acc_step  = (state_reg == S_ACC);
    assign cmd.mul_a     = (state_reg == S_MUL_A);
    assign cmd.mul_b     = (state_reg == S_MUL_B);
    assign cmd.mul_c     = (state_reg == S_MUL_C);
    assign cmd.sum_step  = (state_reg == S_SUM);
    assign cmd.rnd       = (state_reg == S_RND);
    assign cmd.down      = (state_reg == S_DOWN);
    assign cmd.in_result = (state_reg == S_RESULT);
    assign cmd.out_load  = (state_reg == S_RESULT) && st.out_free;

endmodule

// ----- design/rcfr_datapath.sv -----
module rcfr_datapath
    import rcfr_pkg::*;
#(
    parameter int MAX_CELLS  = DEF_MAX_CELLS,
    parameter int FLOW_WIDTH = DEF_FLOW_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic [STAT_W-1:0]   m_tuser,
    input  logic                cfg_valid,
    input  logic [CNT_W-1:0]    cfg_data,
    input  rcfr_cmd_t           cmd,
    output rcfr_stat_t          st
);

    localparam int FW    = FLOW_WIDTH;
    localparam int AW    = $clog2(MAX_CELLS);
    localparam int XW    = (AW > DOWN_W) ? AW : DOWN_W;
    localparam int RW    = ((FW > RUNOFF_W) ? FW : RUNOFF_W) + 1;
    localparam int PW    = FW + COEF_W;
    localparam int SUM_W = (FW + 20 > 64) ? 64 : FW + 20;
    localparam int SW2   = SUM_W - 16;

    localparam logic signed [63:0] FLOW_MAX64 = (64'sd1 <<< (FW - 1)) - 64'sd1;
    localparam logic signed [63:0] FLOW_MIN64 = -FLOW_MAX64 - 64'sd1;
    localparam logic signed [RW-1:0]  MAX_RW  = RW'(FLOW_MAX64);
    localparam logic signed [RW-1:0]  MIN_RW  = RW'(FLOW_MIN64);
    localparam logic signed [SW2-1:0] MAX_SW2 = SW2'(FLOW_MAX64);
    localparam logic signed [SW2-1:0] MIN_SW2 = SW2'(FLOW_MIN64);
    localparam logic signed [FW:0]    MAX_FW1 = (FW + 1)'(FLOW_MAX64);
    localparam logic signed [FW:0]    MIN_FW1 = (FW + 1)'(FLOW_MIN64);
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(64'sd32768);

    // Input fields.
    logic [IDX_W-1:0]           in_idx;
    logic signed [RUNOFF_W-1:0] in_runoff;
    logic [COEFS_W-1:0]         in_coefs;
    logic [DOWN_W-1:0]          in_down;

    assign in_idx    = s_tdata[IDX_LSB +: IDX_W];
    assign in_runoff = signed'(s_tdata[RUNOFF_LSB +: RUNOFF_W]);
    assign in_coefs  = s_tdata[COEFA_LSB +: COEFS_W];
    assign in_down   = s_tdata[DOWN_LSB +: DOWN_W];

    // Configuration register.
    logic [CNT_W-1:0] cell_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= CELL_COUNT_RESET;
        end else if (cfg_valid) begin
            cell_count_reg <= cfg_data;
        end
    end

    // Index check and address of the offered word.
    logic          in_idx_ok;
    logic [XW-1:0] in_idx_x;
    logic [AW-1:0] in_addr;

    assign in_idx_ok = (CNT_W'(in_idx) < cell_count_reg) &&
                       (32'(in_idx) < 32'(MAX_CELLS));
    assign in_idx_x  = XW'(in_idx);
    assign in_addr   = in_idx_x[AW-1:0];

    assign st.route_ok = (s_tuser == FUNC_ROUTE) && in_idx_ok;

    // Per-item registers.
    logic                    func_reg;
    logic                    idx_ok_reg;
    logic [AW-1:0]           addr_reg;
    logic signed [RUNOFF_W-1:0] runoff_reg;
    logic                    hit_reg;
    logic signed [FW-1:0]    acc_new_reg;
    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [FW-1:0]    flow_reg;
    logic                    down_ok_reg;
    logic [AW-1:0]           down_addr_reg;

    // Memory read data.
    logic [COEFS_W-1:0] coef_rd;
    logic [DOWN_W-1:0]  down_rd;
    logic [FW-1:0]      acc_rd;
    logic [FW-1:0]      inprev_rd;
    logic [FW-1:0]      outprev_rd;

    // Runoff into the own accumulator, saturated.
    logic signed [RW-1:0] acc_sum;
    logic signed [FW-1:0] acc_new_next;
    logic                 acc_hit;

    assign acc_sum = RW'(signed'(acc_rd)) + RW'(runoff_reg);

    always_comb begin
        acc_hit = 1'b0;
        if (acc_sum > MAX_RW) begin
            acc_new_next = FW'(MAX_RW);
            acc_hit      = 1'b1;
        end else if (acc_sum < MIN_RW) begin
            acc_new_next = FW'(MIN_RW);
            acc_hit      = 1'b1;
        end else begin
            acc_new_next = FW'(acc_sum);
        end
    end

    // Downstream link decode.
    logic [DOWN_W-1:0] down_m1;
    logic [XW-1:0]     down_x;
    logic [AW-1:0]     down_addr_next;
    logic              down_ok_next;

    assign down_m1        = down_rd - DOWN_W'(1);
    assign down_x         = XW'(down_m1);
    assign down_addr_next = down_x[AW-1:0];
    assign down_ok_next   = (down_rd != '0) && (down_m1 < cell_count_reg) &&
                            (32'(down_m1) < 32'(MAX_CELLS));

    // Shared multiplier, one product per cycle.
    logic signed [COEF_W-1:0] mul_coef;
    logic signed [FW-1:0]     mul_flow;
    logic signed [PW-1:0]     prod_full;

    always_comb begin
        mul_coef = signed'(coef_rd[0 +: COEF_W]);
        mul_flow = acc_new_reg;
        if (cmd.mul_b) begin
            mul_coef = signed'(coef_rd[COEF_W +: COEF_W]);
            mul_flow = signed'(inprev_rd);
        end else if (cmd.mul_c) begin
            mul_coef = signed'(coef_rd[2*COEF_W +: COEF_W]);
            mul_flow = signed'(outprev_rd);
        end
    end

    assign prod_full = mul_coef * mul_flow;

    // Round half up to Q.8 and saturate.
    logic signed [SUM_W-1:0] rnd_sum;
    logic signed [SW2-1:0]   rnd_shift;
    logic signed [FW-1:0]    flow_next;
    logic                    flow_hit;

    assign rnd_sum   = sum_reg + HALF_LSB;
    assign rnd_shift = SW2'(rnd_sum >>> 16);

    always_comb begin
        flow_hit = 1'b0;
        if (rnd_shift > MAX_SW2) begin
            flow_next = FW'(MAX_SW2);
            flow_hit  = 1'b1;
        end else if (rnd_shift < MIN_SW2) begin
            flow_next = FW'(MIN_SW2);
            flow_hit  = 1'b1;
        end else begin
            flow_next = FW'(rnd_shift);
        end
    end

    // Outflow into the downstream accumulator, saturated.
    logic signed [FW:0]   dsum;
    logic signed [FW-1:0] dacc_next;
    logic                 dacc_hit;

    assign dsum = (FW + 1)'(signed'(acc_rd)) + (FW + 1)'(flow_reg);

    always_comb begin
        dacc_hit = 1'b0;
        if (dsum > MAX_FW1) begin
            dacc_next = FW'(MAX_FW1);
            dacc_hit  = 1'b1;
        end else if (dsum < MIN_FW1) begin
            dacc_next = FW'(MIN_FW1);
            dacc_hit  = 1'b1;
        end else begin
            dacc_next = FW'(dsum);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            func_reg   <= s_tuser;
            idx_ok_reg <= in_idx_ok;
            addr_reg   <= in_addr;
            runoff_reg <= in_runoff;
            hit_reg    <= 1'b0;
        end
        if (cmd.acc_step) begin
            acc_new_reg   <= acc_new_next;
            down_ok_reg   <= down_ok_next;
            down_addr_reg <= down_addr_next;
            hit_reg       <= hit_reg | acc_hit;
        end
        if (cmd.mul_a || cmd.mul_b || cmd.mul_c) begin
            prod_reg <= SUM_W'(prod_full);
        end
        if (cmd.mul_b) begin
            sum_reg <= prod_reg;
        end
        if (cmd.mul_c || cmd.sum_step) begin
            sum_reg <= sum_reg + prod_reg;
        end
        if (cmd.rnd) begin
            flow_reg <= flow_next;
            hit_reg  <= hit_reg | flow_hit;
        end
        if (cmd.down && down_ok_reg) begin
            hit_reg <= hit_reg | dacc_hit;
        end
    end

    // Memory write control.
    logic load_wr;
    logic route_item;

    assign load_wr    = cmd.take && (s_tuser == FUNC_LOAD) && in_idx_ok;
    assign route_item = (func_reg == FUNC_ROUTE) && idx_ok_reg;

    logic          acc_we;
    logic [AW-1:0] acc_waddr;
    logic [FW-1:0] acc_wdata;
    logic [AW-1:0] acc_raddr;

    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = in_addr;
        acc_wdata = '0;
        if (load_wr) begin
            acc_we = 1'b1;
        end else if (cmd.down) begin
            acc_we    = down_ok_reg;
            acc_waddr = down_addr_reg;
            acc_wdata = dacc_next;
        end else if (cmd.in_result) begin
            // A cell that feeds itself still ends with a cleared accumulator.
            acc_we    = route_item;
            acc_waddr = addr_reg;
        end
    end

    assign acc_raddr = cmd.acc_step ? down_addr_next : in_addr;

    rcfr_ram #(.WIDTH(COEFS_W), .DEPTH(MAX_CELLS)) u_coef_ram (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (in_addr),
        .wr_data (in_coefs),
        .rd_en   (cmd.take),
        .rd_addr (in_addr),
        .rd_data (coef_rd)
    );

    rcfr_ram #(.WIDTH(DOWN_W), .DEPTH(MAX_CELLS)) u_down_ram (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (in_addr),
        .wr_data (in_down),
        .rd_en   (cmd.take),
        .rd_addr (in_addr),
        .rd_data (down_rd)
    );

    rcfr_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_acc_ram (
        .aclk    (aclk),
        .wr_en   (acc_we),
        .wr_addr (acc_waddr),
        .wr_data (acc_wdata),
        .rd_en   (cmd.take || cmd.acc_step),
        .rd_addr (acc_raddr),
        .rd_data (acc_rd)
    );

    rcfr_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_inprev_ram (
        .aclk    (aclk),
        .wr_en   (load_wr || cmd.mul_a),
        .wr_addr (cmd.mul_a ? addr_reg : in_addr),
        .wr_data (cmd.mul_a ? acc_new_reg : '0),
        .rd_en   (cmd.take),
        .rd_addr (in_addr),
        .rd_data (inprev_rd)
    );

    rcfr_ram #(.WIDTH(FW), .DEPTH(MAX_CELLS)) u_outprev_ram (
        .aclk    (aclk),
        .wr_en   (load_wr || cmd.rnd),
        .wr_addr (cmd.rnd ? addr_reg : in_addr),
        .wr_data (cmd.rnd ? flow_next : '0),
        .rd_en   (cmd.take),
        .rd_addr (in_addr),
        .rd_data (outprev_rd)
    );

    // Output register.
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;
    logic [STAT_W-1:0]       m_tuser_reg;
    logic signed [OUT_W-1:0] flow_out;

    assign flow_out = OUT_W'(flow_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (!idx_ok_reg) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= STAT_RANGE;
            end else if (func_reg == FUNC_LOAD) begin
                m_tdata_reg <= '0;
                m_tuser_reg <= STAT_OK;
            end else begin
                m_tdata_reg <= flow_out;
                m_tuser_reg <= hit_reg ? STAT_SAT : STAT_OK;
            end
        end
    end

    assign st.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign m_tuser     = m_tuser_reg;

endmodule
